>>> hw/rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbps_pkg;

    // Fixed field widths.
    localparam int ADDR_W        = 48;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int LEN_W         = 5;
    localparam int CARE_W        = 16;
    localparam int PAT_REG_BYTES = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd3;

    // Configuration as seen by the compare engine.
    typedef struct packed {
        logic [PAT_REG_BYTES*8-1:0] pattern;
        logic [CARE_W-1:0]          care_mask;
        logic [LEN_W-1:0]           used_len;
    } t_cfg;

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              region_start;
        logic              scan_start;
        logic              scan_end;
    } t_item;

endpackage

>>> hw/rtl/mbps_cfg.sv
// Configuration registers and effective pattern length for the scanner.
`timescale 1ns / 1ps

module mbps_cfg
    import mbps_pkg::*;
#(
    parameter int CAP = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [CFG_W-1:0]  r_pat_lo;
    logic [CFG_W-1:0]  r_pat_hi;
    logic [CARE_W-1:0] r_care;
    logic [LEN_W-1:0]  r_len;

    // Register writes; reset restores the documented defaults.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '1;
            r_len    <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAT_LO:  r_pat_lo <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi <= i_cfg_data;
                CFG_CARE:    r_care   <= i_cfg_data[CARE_W-1:0];
                CFG_PAT_LEN: r_len    <= i_cfg_data[LEN_W-1:0];
            endcase
        end
    end

    // A length of zero acts as one; a length above the window saturates.
    always_comb begin
        o_cfg.pattern   = {r_pat_hi, r_pat_lo};
        o_cfg.care_mask = r_care;
        if (r_len == '0) begin
            o_cfg.used_len = LEN_W'(1);
        end else if (r_len > LEN_W'(CAP)) begin
            o_cfg.used_len = LEN_W'(CAP);
        end else begin
            o_cfg.used_len = r_len;
        end
    end

endmodule

>>> hw/rtl/mbps_engine.sv
// Byte window, fill count, match flag and masked compare for the scanner.
`timescale 1ns / 1ps

module mbps_engine
    import mbps_pkg::*;
#(
    parameter int WIN = 16,
    parameter int AW  = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_item             i_item,
    input  t_cfg              i_cfg,
    output logic              o_produce,
    output logic              o_found,
    output logic [ADDR_W-1:0] o_match_address
);

    localparam int IDX_W  = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int FILL_W = $clog2(WIN + 1);

    logic [7:0]        r_win [WIN];
    logic [7:0]        n_win [WIN];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_seen;
    logic              n_seen;
    logic              skip;
    logic [FILL_W-1:0] base_fill;
    logic              all_match;
    logic              hit;
    logic [LEN_W-1:0]  pos;
    logic [AW-1:0]     start_addr;

    // A word is ignored while a match stands and no new scan begins.
    assign skip      = r_seen && !i_item.scan_start;
    assign base_fill = (i_item.region_start || i_item.scan_start) ? '0 : r_fill;

    // Shift the new byte into the window and count valid entries.
    always_comb begin
        n_win[0] = i_item.data_byte;
        for (int k = 1; k < WIN; k++) begin
            n_win[k] = r_win[k-1];
        end
        if (base_fill < FILL_W'(WIN)) begin
            n_fill = base_fill + FILL_W'(1);
        end else begin
            n_fill = base_fill;
        end
    end

    // Pattern byte i lines up with the window entry len-1-i.
    always_comb begin
        all_match = 1'b1;
        pos       = '0;
        for (int i = 0; i < WIN; i++) begin
            pos = i_cfg.used_len - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < i_cfg.used_len) && i_cfg.care_mask[i] &&
                (n_win[pos[IDX_W-1:0]] != i_cfg.pattern[i*8 +: 8])) begin
                all_match = 1'b0;
            end
        end
    end

    assign hit = !skip && all_match &&
                 ((LEN_W+1)'(n_fill) >= (LEN_W+1)'(i_cfg.used_len));
    assign n_seen = hit;

    // Result of this word: a match, or not found at the end of the scan.
    assign start_addr      = i_item.byte_address[AW-1:0] - AW'(i_cfg.used_len - LEN_W'(1));
    assign o_produce       = i_step && !skip && (hit || i_item.scan_end);
    assign o_found         = hit;
    assign o_match_address = hit ? ADDR_W'(start_addr) : '0;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_seen <= 1'b0;
        end else if (i_step && !skip) begin
            r_fill <= n_fill;
            r_seen <= n_seen;
        end
    end

    // Window contents; entries beyond the fill count are never compared.
    always_ff @(posedge i_clk) begin
        if (i_step && !skip) begin
            for (int k = 0; k < WIN; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule

>>> hw/rtl/masked_byte_pattern_scanner_core.sv
// An accepted word is held in the input register; its result then passes into the result
// register once that register is free, and is offered on the result channel from there.
// Throughput: one word per cycle unless a waiting result is not taken; the input register feeds
// the compare and result register. A waiting result that is not taken blocks a full input register.
// Reset (synchronous, active low) clears both valid flags, the fill count and the match flag,
// and returns the configuration registers to their defaults.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_core
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN  = 16,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic [ADDR_W-1:0]    i_byte_address,
    input  logic                 i_region_start,
    input  logic                 i_scan_start,
    input  logic                 i_scan_end,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_found,
    output logic [ADDR_W-1:0]    o_match_address
);

    localparam int WIN = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;
    localparam int AW  = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;

    t_cfg              cfg;
    t_item             r_in;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_addr;
    logic              step;
    logic              produce;
    logic              found;
    logic [ADDR_W-1:0] match_addr;

    mbps_cfg #(
        .CAP(WIN)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The held word is processed once the result register can take its result.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    mbps_engine #(
        .WIN(WIN),
        .AW (AW)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_item          (r_in),
        .i_cfg           (cfg),
        .o_produce       (produce),
        .o_found         (found),
        .o_match_address (match_addr)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= produce;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.data_byte    <= i_data_byte;
            r_in.byte_address <= i_byte_address;
            r_in.region_start <= i_region_start;
            r_in.scan_start   <= i_scan_start;
            r_in.scan_end     <= i_scan_end;
        end
    end

    // Payload of the result register.
    always_ff @(posedge i_clk) begin
        if (step && produce) begin
            r_found <= found;
            r_addr  <= match_addr;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_addr;

endmodule
